/* rtl/wss_pkg.sv */
// Package: shared types, constants and command structs for the seed selector.
package wss_pkg;
  localparam int unsigned MaxEntriesDefault = 1024;
  localparam int unsigned FracBitsDefault   = 16;
  localparam int unsigned FracScale         = 65535;

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_WEIGHT  = 2'd1;
  localparam logic [1:0] OP_UNIFORM = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // datapath commands from the controller
  typedef struct packed {
    logic load_item;   // capture input item, clear sums
    logic add_write;   // write new entry at count
    logic div_start;   // start divider on read data
    logic acc_total;   // add weight to total
    logic acc_prefix;  // add weight to prefix
    logic scan_inc;    // advance scan index
    logic scan_clr;    // reset scan index
    logic cmp_load;    // start compare of prefix vs total
    logic pick_scan;   // latch scan index as pick
    logic mod_start;   // start modulo unit
    logic rd_pick;     // read pick entry
    logic use_write;   // write incremented use count
    logic out_load;    // load result register
    logic [1:0] out_status;
    logic out_zero;    // zero payload fields
  } wss_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mod_done;
    logic cmp_done;
    logic reaches;
    logic scan_last;   // scan index is count-1
    logic full;
    logic empty;
  } wss_stat_t;
endpackage

/* rtl/wss_if.sv */
// Interface: valid/ready channel with a generic payload.
interface wss_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/weighted_seed_selector_unit.sv */
// Top level: weighted seed selector, controller plus datapath.
// Roulette-wheel selector over a table of (coverage, uses) entries.
// Input channel in_*: opcode, coverage, random_value; one item per operation.
// Result channel out_*: status, entry_index, entry_coverage, entry_uses,
// exactly one result item per input item, in order.
// Uniform select is paced by the bit-serial modulo unit (16 steps). Weighted
// select walks the table twice; each entry costs a read, a read wait plus a
// NW-step serial divider (NW = 16 + FRAC_BITS), and the second walk adds a
// 16-step serial compare per visited entry and stops at the pick.
// One item is in work at a time; a new item is taken only in idle, once the
// previous result has left or leaves in the same cycle.
// Reset (rst_n low, synchronous) empties the table; stores need no clearing,
// only entries below the count are read. A stalled receiver holds the result
// and the block accepts no further item until it is taken.
module weighted_seed_selector_unit #(
  parameter int unsigned MAX_ENTRIES = wss_pkg::MaxEntriesDefault,
  parameter int unsigned FRAC_BITS   = wss_pkg::FracBitsDefault
) (
  input  logic clk,
  input  logic rst_n,
  wss_if.sink   in_ch,
  wss_if.source out_ch
);
  import wss_pkg::*;

  wss_cmd_t  cmd;
  wss_stat_t stat;

  // control: sequences each operation
  wss_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_opcode(in_ch.data.opcode),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .stat
  );

  // datapath: stores, divider, compare and modulo units, result register
  wss_datapath #(.MAX_ENTRIES(MAX_ENTRIES), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_coverage(in_ch.data.coverage),
    .in_random_value(in_ch.data.random_value),
    .res_status(out_ch.data.status),
    .res_index(out_ch.data.entry_index),
    .res_coverage(out_ch.data.entry_coverage),
    .res_uses(out_ch.data.entry_uses)
  );

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !out_ch.valid || $past(out_ch.valid))
    else $error("result before work");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.data.status != 2'd3) else $error("bad status");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result dropped");
endmodule

/* rtl/wss_ram.sv */
// Generic single-port RAM with registered read.
module wss_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* rtl/wss_datapath.sv */
// Datapath: entry stores, serial divider, serial compare multiplier, modulo unit.
module wss_datapath #(
  parameter int unsigned MAX_ENTRIES = wss_pkg::MaxEntriesDefault,
  parameter int unsigned FRAC_BITS   = wss_pkg::FracBitsDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  wss_pkg::wss_cmd_t cmd,
  output wss_pkg::wss_stat_t stat,
  input  logic [15:0]       in_coverage,
  input  logic [15:0]       in_random_value,
  output logic [1:0]        res_status,
  output logic [9:0]        res_index,
  output logic [15:0]       res_coverage,
  output logic [15:0]       res_uses
);
  import wss_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned NW = 16 + FRAC_BITS;            // dividend width
  localparam int unsigned SW = NW + CW;                   // sum width
  localparam int unsigned PW = SW + 16;                   // product width
  localparam logic [NW-1:0] Floor = NW'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

  logic [CW-1:0] count_r;
  logic [AW-1:0] scan_r, pick_r;
  logic [15:0]   rnd_r, cov_in_r, cov_q, use_q;
  logic [SW-1:0] total_r, prefix_r;

  // Stores
  logic          cov_we, use_we;
  logic [AW-1:0] ram_addr;
  logic [15:0]   use_wdata;
  assign cov_we    = cmd.add_write;
  assign use_we    = cmd.add_write | cmd.use_write;
  assign ram_addr  = cmd.add_write ? count_r[AW-1:0] :
                     (cmd.rd_pick | cmd.use_write) ? pick_r : scan_r;
  assign use_wdata = cmd.add_write ? 16'd0 : ((use_q == 16'hFFFF) ? use_q : use_q + 16'd1);

  wss_ram #(.WIDTH(16), .DEPTH(MAX_ENTRIES)) u_cov_ram (
    .clk, .we(cov_we), .addr(ram_addr), .wdata(cov_in_r), .rdata(cov_q));
  wss_ram #(.WIDTH(16), .DEPTH(MAX_ENTRIES)) u_use_ram (
    .clk, .we(use_we), .addr(ram_addr), .wdata(use_wdata), .rdata(use_q));

  // Restoring divider, one quotient bit per cycle
  logic [NW-1:0] dq_r;
  logic [16:0]   drem_r, dden_r;
  logic [$clog2(NW+1)-1:0] dcnt_r;
  logic          dbusy_r;
  logic [17:0]   dtrial;
  logic [NW-1:0] weight;
  assign dtrial = {drem_r, dq_r[NW-1]} - {1'b0, dden_r};
  assign weight = (dq_r < Floor) ? Floor : dq_r;

  // Compare: prefix*65535 vs total*r, shift-add one bit per cycle
  logic [PW-1:0] pa_r, pb_r;
  logic [15:0]   mr_r;
  logic [4:0]    mcnt_r;
  logic          mbusy_r;
  logic [PW-1:0] a_full;
  assign a_full = {prefix_r, 16'd0} - PW'(prefix_r);

  // Modulo: restoring, one bit per cycle
  logic [15:0]   mq_r;
  logic [CW:0]   mrem_r;
  logic [4:0]    mocnt_r;
  logic          mobusy_r;
  logic [CW+1:0] mtrial;
  assign mtrial = {mrem_r, mq_r[15]} - (CW+2)'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      dbusy_r  <= 1'b0;
      mbusy_r  <= 1'b0;
      mobusy_r <= 1'b0;
      res_status <= ST_OK;
    end else begin
      if (cmd.load_item) begin
        rnd_r    <= in_random_value;
        cov_in_r <= in_coverage;
        total_r  <= '0;
        prefix_r <= '0;
      end
      if (cmd.add_write) count_r <= count_r + CW'(1);
      if (cmd.scan_clr) scan_r <= '0;
      else if (cmd.scan_inc) scan_r <= scan_r + AW'(1);
      if (cmd.div_start) begin
        dq_r    <= {cov_q, FRAC_BITS'(0)};
        drem_r  <= '0;
        dden_r  <= {1'b0, use_q} + 17'd1;
        dcnt_r  <= '0;
        dbusy_r <= 1'b1;
      end else if (dbusy_r) begin
        if (!dtrial[17]) drem_r <= dtrial[16:0];
        else drem_r <= {drem_r[15:0], dq_r[NW-1]};
        dq_r   <= {dq_r[NW-2:0], ~dtrial[17]};
        dcnt_r <= dcnt_r + ($bits(dcnt_r))'(1);
        if (dcnt_r == ($bits(dcnt_r))'(NW - 1)) dbusy_r <= 1'b0;
      end
      if (cmd.acc_total)  total_r  <= total_r + SW'(weight);
      if (cmd.acc_prefix) prefix_r <= prefix_r + SW'(weight);
      if (cmd.cmp_load) begin
        pa_r    <= PW'(0);
        pb_r    <= PW'(total_r);
        mr_r    <= rnd_r;
        mcnt_r  <= '0;
        mbusy_r <= 1'b1;
      end else if (mbusy_r) begin
        if (mr_r[0]) pa_r <= pa_r + pb_r;
        pb_r   <= pb_r << 1;
        mr_r   <= mr_r >> 1;
        mcnt_r <= mcnt_r + 5'd1;
        if (mcnt_r == 5'd15) mbusy_r <= 1'b0;
      end
      if (cmd.pick_scan) pick_r <= scan_r;
      if (cmd.mod_start) begin
        mq_r     <= rnd_r;
        mrem_r   <= '0;
        mocnt_r  <= '0;
        mobusy_r <= 1'b1;
      end else if (mobusy_r) begin
        if (!mtrial[CW+1]) mrem_r <= mtrial[CW:0];
        else mrem_r <= {mrem_r[CW-1:0], mq_r[15]};
        mq_r    <= mq_r << 1;
        mocnt_r <= mocnt_r + 5'd1;
        if (mocnt_r == 5'd15) begin
          mobusy_r <= 1'b0;
          pick_r   <= !mtrial[CW+1] ? AW'(mtrial[CW:0]) : AW'({mrem_r[CW-1:0], mq_r[15]});
        end
      end
      if (cmd.out_load) begin
        res_status <= cmd.out_status;
        if (cmd.out_zero) begin
          res_index <= '0; res_coverage <= '0; res_uses <= '0;
        end else if (cmd.add_write) begin
          res_index <= 10'(count_r); res_coverage <= cov_in_r; res_uses <= '0;
        end else begin
          res_index <= 10'(pick_r); res_coverage <= cov_q;
          res_uses  <= cmd.use_write ? use_wdata : use_q;
        end
      end
    end
  end

  assign stat.div_done  = !dbusy_r;
  assign stat.mod_done  = !mobusy_r;
  assign stat.cmp_done  = !mbusy_r;
  assign stat.reaches   = a_full >= pa_r;
  assign stat.scan_last = (CW'(scan_r) == count_r - CW'(1));
  assign stat.full      = count_r >= CW'(MAX_ENTRIES);
  assign stat.empty     = count_r == '0;
endmodule

/* rtl/wss_ctrl.sv */
// Controller: sequences add, uniform and two-pass weighted select.
module wss_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  output logic               out_valid,
  input  logic               out_ready,
  output wss_pkg::wss_cmd_t  cmd,
  input  wss_pkg::wss_stat_t stat
);
  import wss_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_T_RD, S_T_LD, S_T_DIV, S_P_RD, S_P_LD, S_P_DIV, S_P_CMP,
    S_U_MOD, S_RD_PICK, S_WB, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic [1:0] op_r, op_nxt;
  logic   dwait_r, dwait_nxt;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    dwait_nxt     = dwait_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: if (in_valid && in_ready) begin
        cmd.load_item = 1'b1;
        op_nxt = in_opcode;
        state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        cmd.scan_clr = 1'b1;
        if (op_r == OP_ADD) begin
          cmd.out_load = 1'b1;
          if (stat.full) begin
            cmd.out_status = ST_FULL; cmd.out_zero = 1'b1;
          end else begin
            cmd.add_write = 1'b1;
          end
          state_nxt = S_OUT;
        end else if (op_r != OP_WEIGHT && op_r != OP_UNIFORM) begin
          cmd.out_load = 1'b1; cmd.out_zero = 1'b1; state_nxt = S_OUT;
        end else if (stat.empty) begin
          cmd.out_load = 1'b1; cmd.out_zero = 1'b1; cmd.out_status = ST_EMPTY;
          state_nxt = S_OUT;
        end else if (op_r == OP_UNIFORM) begin
          cmd.mod_start = 1'b1; state_nxt = S_U_MOD;
        end else begin
          state_nxt = S_T_RD;
        end
      end
      // read issued at scan index, data valid in the next cycle, in S_T_LD
      S_T_RD: state_nxt = S_T_LD;
      S_T_LD: begin
        cmd.div_start = 1'b1; state_nxt = S_T_DIV;
      end
      S_T_DIV: if (stat.div_done) begin
        cmd.acc_total = 1'b1;
        if (stat.scan_last) begin
          cmd.scan_clr = 1'b1;
        end else begin
          cmd.scan_inc = 1'b1;
        end
        state_nxt = stat.scan_last ? S_P_RD : S_T_RD;
      end
      S_P_RD: state_nxt = S_P_LD;
      S_P_LD: begin
        cmd.div_start = 1'b1; state_nxt = S_P_DIV;
      end
      S_P_DIV: if (stat.div_done) begin
        cmd.acc_prefix = 1'b1; dwait_nxt = 1'b1; state_nxt = S_P_CMP;
      end
      S_P_CMP: begin
        if (dwait_r) begin
          cmd.cmp_load = 1'b1; dwait_nxt = 1'b0;
        end else if (stat.cmp_done) begin
          if (stat.reaches || stat.scan_last) begin
            cmd.pick_scan = 1'b1; state_nxt = S_RD_PICK;
          end else begin
            cmd.scan_inc = 1'b1; state_nxt = S_P_RD;
          end
        end
      end
      S_U_MOD: if (stat.mod_done) state_nxt = S_RD_PICK;
      S_RD_PICK: begin
        cmd.rd_pick = 1'b1; state_nxt = S_WB;
      end
      S_WB: begin
        cmd.rd_pick  = 1'b1;
        cmd.out_load = 1'b1;
        cmd.use_write = (op_r == OP_WEIGHT);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      op_r        <= OP_ADD;
      dwait_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      op_r        <= op_nxt;
      dwait_r     <= dwait_nxt;
    end
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> state_r == S_IDLE) else $error("accept outside idle");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid_r || out_ready) else $error("accept over pending result");
  a_wb_only_weight: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.use_write |-> op_r == OP_WEIGHT) else $error("use write on non-weighted op");
  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |=> out_valid_r) else $error("result not presented");
endmodule

/* tb/tb.sv */
// Testbench for weighted_seed_selector_unit: directed and random items, scoreboard check.
`timescale 1ns / 1ps

module tb;
  import wss_pkg::*;

  localparam int unsigned TableDepth  = 1024;
  localparam longint unsigned WeightMin = ((64'd1 << 16) + 5) / 10;
  localparam logic [1:0] OP_NONE = 2'd3;  // unused opcode, block answers with zeros

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] coverage;
    logic [15:0] random_value;
  } sel_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  entry_index;
    logic [15:0] entry_coverage;
    logic [15:0] entry_uses;
  } sel_res_t;

  // drain: hold the item back until every pending result has come
  typedef struct {
    sel_req_t req;
    bit       drain;
  } req_slot_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  wss_if #(.payload_t(sel_req_t)) req_ch ();
  wss_if #(.payload_t(sel_res_t)) res_ch ();

  weighted_seed_selector_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch.sink),
    .out_ch (res_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow table of the selector
  logic [15:0] shadow_cov [TableDepth];
  logic [15:0] shadow_uses [TableDepth];
  int unsigned shadow_count = 0;

  req_slot_t   pending_reqs [$];
  sel_res_t    expected_res [$];
  int unsigned accepted = 0;
  int unsigned errors = 0;
  logic        rx_hold = 1'b0;
  int unsigned gen_count = 0;   // table size as seen by the stimulus generator

  // Idle percentages per phase: sender busy-ish first, then receiver, then none.
  function automatic int unsigned send_idle_pct();
    if (accepted < 50) return 19;
    if (accepted < 100) return 78;
    return 0;
  endfunction

  function automatic int unsigned recv_idle_pct();
    if (accepted < 50) return 78;
    if (accepted < 100) return 19;
    return 0;
  endfunction

  function automatic longint unsigned entry_weight(int unsigned idx);
    longint unsigned w;
    w = ({48'd0, shadow_cov[idx]} << 16) / ({48'd0, shadow_uses[idx]} + 64'd1);
    return (w < WeightMin) ? WeightMin : w;
  endfunction

  // Computes the selector's answer and updates the shadow table.
  function automatic sel_res_t select_outcome(sel_req_t req);
    sel_res_t res;
    longint unsigned total, prefix;
    int unsigned pick;
    res = '0;
    if (req.opcode == OP_ADD) begin
      if (shadow_count >= TableDepth) begin
        res.status = ST_FULL;
      end else begin
        shadow_cov[shadow_count]  = req.coverage;
        shadow_uses[shadow_count] = 16'd0;
        res.entry_index    = shadow_count[9:0];
        res.entry_coverage = req.coverage;
        shadow_count++;
      end
    end else if (req.opcode == OP_NONE) begin
      // zeros, status ok
    end else if (shadow_count == 0) begin
      res.status = ST_EMPTY;
    end else if (req.opcode == OP_UNIFORM) begin
      pick = req.random_value % shadow_count;
      res.entry_index    = pick[9:0];
      res.entry_coverage = shadow_cov[pick];
      res.entry_uses     = shadow_uses[pick];
    end else begin
      total = 0;
      for (int unsigned i = 0; i < shadow_count; i++) total += entry_weight(i);
      pick = shadow_count - 1;
      prefix = 0;
      // total < 2^42, so both products fit in 64 bits
      for (int unsigned i = 0; i < shadow_count; i++) begin
        prefix += entry_weight(i);
        if (prefix * 64'd65535 >= total * {48'd0, req.random_value}) begin
          pick = i;
          break;
        end
      end
      if (shadow_uses[pick] != 16'hFFFF) shadow_uses[pick]++;
      res.entry_index    = pick[9:0];
      res.entry_coverage = shadow_cov[pick];
      res.entry_uses     = shadow_uses[pick];
    end
    return res;
  endfunction

  function automatic void queue_req(logic [1:0] op, logic [15:0] cov, logic [15:0] rnd,
                                    bit drain = 1'b0);
    req_slot_t s;
    s.req.opcode       = op;
    s.req.coverage     = cov;
    s.req.random_value = rnd;
    s.drain            = drain;
    pending_reqs = {pending_reqs, s};
    if (op == OP_ADD && gen_count < TableDepth) gen_count++;
  endfunction

  // Driver: one assignment per signal per edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_res = {expected_res, select_outcome(req_ch.data)};
        accepted++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() != 0 &&
            !(pending_reqs[0].drain && expected_res.size() != 0) &&
            $urandom_range(99) >= send_idle_pct()) begin
          req_ch.data  <= pending_reqs[0].req;
          req_ch.valid <= 1'b1;
          pending_reqs.delete(0);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness
  always @(posedge clk) begin
    if (!rst_n) res_ch.ready <= 1'b0;
    else res_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct());
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk) begin
    sel_res_t want, got;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got = res_ch.data;
      if (expected_res.size() == 0) begin
        $error("unexpected result item: %p", got);
        errors++;
      end else begin
        want = expected_res.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        if (got.entry_index !== want.entry_index) begin
          $error("entry_index: expected %0d, got %0d", want.entry_index, got.entry_index);
          errors++;
        end
        if (got.entry_coverage !== want.entry_coverage) begin
          $error("entry_coverage: expected %0d, got %0d",
                 want.entry_coverage, got.entry_coverage);
          errors++;
        end
        if (got.entry_uses !== want.entry_uses) begin
          $error("entry_uses: expected %0d, got %0d", want.entry_uses, got.entry_uses);
          errors++;
        end
      end
    end
  end

  // Long receiver stall while items keep coming: block must back up its input.
  initial begin
    wait (accepted >= 120);
    @(posedge clk) rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Stimulus and end of run
  initial begin
    int unsigned pick;
    logic [15:0] cov;
    // empty table, unused opcode
    queue_req(OP_WEIGHT, 16'd0, 16'hFFFF);
    queue_req(OP_UNIFORM, 16'hFFFF, 16'd0);
    queue_req(OP_NONE, 16'hFFFF, 16'hFFFF);
    // coverage extremes; zero coverage falls onto the weight floor
    queue_req(OP_ADD, 16'd0, 16'hFFFF);
    queue_req(OP_ADD, 16'hFFFF, 16'd0);
    queue_req(OP_ADD, 16'd1, 16'hAAAA);
    queue_req(OP_ADD, 16'h5555, 16'h5555);
    queue_req(OP_WEIGHT, 16'd0, 16'd0);
    queue_req(OP_WEIGHT, 16'd0, 16'hFFFF);
    queue_req(OP_WEIGHT, 16'hFFFF, 16'd32768);
    queue_req(OP_WEIGHT, 16'd0, 16'd1);
    queue_req(OP_UNIFORM, 16'd0, 16'hFFFF);
    queue_req(OP_UNIFORM, 16'd0, 16'd3);
    queue_req(OP_NONE, 16'd0, 16'd0);
    queue_req(OP_WEIGHT, 16'd0, 16'hFFFE, 1'b1);

    // Random part, table stays small so weighted picks stay cheap
    for (int n = 0; n < 120; n++) begin
      pick = $urandom_range(99);
      case ($urandom_range(3))
        0: cov = 16'd0;
        1: cov = 16'hFFFF;
        2: cov = 16'($urandom_range(3000));
        default: cov = 16'($urandom);
      endcase
      if (pick < 30 && gen_count < 80) queue_req(OP_ADD, cov, 16'($urandom));
      else if (pick < 70) queue_req(OP_WEIGHT, cov, 16'($urandom));
      else if (pick < 95) queue_req(OP_UNIFORM, cov, 16'($urandom));
      else queue_req(OP_NONE, cov, 16'($urandom));
    end

    // A few more entries after a drain, then picks at the value extremes
    queue_req(OP_ADD, 16'($urandom), 16'($urandom), 1'b1);
    queue_req(OP_ADD, 16'hFFFF, 16'hFFFF);
    queue_req(OP_ADD, 16'd0, 16'd0);
    queue_req(OP_UNIFORM, 16'd0, 16'd1023);
    queue_req(OP_UNIFORM, 16'd0, 16'hFFFF);
    queue_req(OP_WEIGHT, 16'd0, 16'd0);
    queue_req(OP_WEIGHT, 16'd0, 16'd32768);
    queue_req(OP_WEIGHT, 16'd0, 16'hFFFF);
    queue_req(OP_NONE, 16'd0, 16'd0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_reqs.size() == 0 && !req_ch.valid);
    wait (expected_res.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #40ms;
    $display("FAILURE");
    $finish;
  end

endmodule
